// ===== hw/rtl/rfft_ub_pkg.sv =====
// ----------------------------------------------------------------------------
// Real-FFT unpack butterfly package
// Widths, item kind codes and the output saturation helper.
// ----------------------------------------------------------------------------
package rfft_ub_pkg;

    // Sample and twiddle formats.
    localparam int SAMPLE_WIDTH      = 24;
    localparam int TWIDDLE_FRAC_BITS = 16;
    localparam int TWIDDLE_WIDTH     = 18;
    localparam int OUT_WIDTH         = SAMPLE_WIDTH + 3;

    // Internal datapath widths.
    localparam int G_WIDTH   = SAMPLE_WIDTH + 1;               // sums of two samples
    localparam int P_WIDTH   = TWIDDLE_WIDTH + G_WIDTH;        // one twiddle product
    localparam int S_WIDTH   = P_WIDTH + 1;                    // sum of two products
    localparam int T_WIDTH   = S_WIDTH - TWIDDLE_FRAC_BITS;    // after the Q shift
    localparam int R_BASE    = (T_WIDTH > SAMPLE_WIDTH + 2) ? T_WIDTH : SAMPLE_WIDTH + 2;
    localparam int R_WIDTH   = R_BASE + 1;                     // before saturation

    // Item kind codes.
    localparam logic [1:0] KIND_DC   = 2'd0;
    localparam logic [1:0] KIND_PAIR = 2'd1;
    localparam logic [1:0] KIND_MID  = 2'd2;

    typedef logic signed [OUT_WIDTH-1:0] out_word_t;
    typedef logic signed [R_WIDTH-1:0]   wide_word_t;

    typedef struct packed {
        out_word_t value;
        logic      clip;
    } sat_res_t;

    localparam out_word_t OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam out_word_t OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    // Clip a wide value to the signed output range.
    function automatic sat_res_t saturate(input wide_word_t v);
        sat_res_t                          res;
        logic [R_WIDTH-OUT_WIDTH:0]        top_bits;
        top_bits = v[R_WIDTH-1:OUT_WIDTH-1];
        if ((&top_bits) || !(|top_bits)) begin
            res.value = v[OUT_WIDTH-1:0];
            res.clip  = 1'b0;
        end else begin
            res.value = v[R_WIDTH-1] ? OUT_MIN : OUT_MAX;
            res.clip  = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/real_fft_unpack_butterfly.sv =====
// ----------------------------------------------------------------------------
// Real-FFT unpack butterfly
// Split butterfly for the post-processing pass of a real FFT computed as a
// packed complex transform, one word per clock while m_ready stays high.
// ----------------------------------------------------------------------------
// Usage:
// The feeder presents one word on the s_ channel: a kind code, the top
// element, the mirrored bottom element and a Q1.16 twiddle. Addressing,
// loop counts and twiddle stride are entirely the feeder's job. Each input
// word produces exactly one result word on the m_ channel, in order.
// The datapath is a three-register pipeline: input register, twiddle
// product register and result register. An accepted word passes through the
// product register to the result register, which presents it on m_. The
// rate is one word per cycle while m_ready is high, set by the four parallel
// twiddle multipliers feeding one registered add/shift/saturate stage.
// Each stage has its own valid bit and takes a new word whenever it is
// empty or its successor takes its word, so bubbles close up and s_ready
// stays high while downstream stages have room.
// When the receiver stalls, the result register holds its word and the
// pipeline fills behind it; s_ready falls once all three stages are full.
// A synchronous active-low reset empties the pipeline and sets the
// direction register to forward. The direction register should only be
// written while the pipeline is empty.
// ----------------------------------------------------------------------------
module real_fft_unpack_butterfly (
    input  logic                                           aclk,
    input  logic                                           aresetn,

    // Configuration: direction_forward register.
    input  logic                                           cfg_wr_en,
    input  logic                                           cfg_wr_data,

    // Input words.
    input  logic                                           s_valid,
    output logic                                           s_ready,
    input  logic [1:0]                                     s_kind,
    input  logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_top_re,
    input  logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_top_im,
    input  logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_bottom_re,
    input  logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_bottom_im,
    input  logic signed [rfft_ub_pkg::TWIDDLE_WIDTH-1:0]   s_twiddle_re,
    input  logic signed [rfft_ub_pkg::TWIDDLE_WIDTH-1:0]   s_twiddle_im,

    // Result words.
    output logic                                           m_valid,
    input  logic                                           m_ready,
    output logic signed [rfft_ub_pkg::OUT_WIDTH-1:0]       m_out_top_re,
    output logic signed [rfft_ub_pkg::OUT_WIDTH-1:0]       m_out_top_im,
    output logic signed [rfft_ub_pkg::OUT_WIDTH-1:0]       m_out_bottom_re,
    output logic signed [rfft_ub_pkg::OUT_WIDTH-1:0]       m_out_bottom_im,
    output logic                                           m_saturated
);

    localparam int SW = rfft_ub_pkg::SAMPLE_WIDTH;
    localparam int TW = rfft_ub_pkg::TWIDDLE_WIDTH;
    localparam int GW = rfft_ub_pkg::G_WIDTH;
    localparam int PW = rfft_ub_pkg::P_WIDTH;
    localparam int SUMW = rfft_ub_pkg::S_WIDTH;
    localparam int TRW = rfft_ub_pkg::T_WIDTH;
    localparam int RW = rfft_ub_pkg::R_WIDTH;
    localparam int FB = rfft_ub_pkg::TWIDDLE_FRAC_BITS;

    // ------------------------------------------------------------------
    // Direction register. Forward after reset; only bit 0 is meaningful.
    // ------------------------------------------------------------------
    logic dir_fwd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_fwd_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            dir_fwd_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Per-stage handshake. A stage loads when it is empty or when the
    // stage after it is taking its current word.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;
    logic in_ready;
    logic prod_ready;
    logic out_ready;

    assign out_ready  = !out_valid_reg || m_ready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign s_ready    = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register. The direction bit travels with the word.
    // ------------------------------------------------------------------
    logic [1:0]            kind_in_reg;
    logic                  fwd_in_reg;
    logic signed [SW-1:0]  a_re_reg;
    logic signed [SW-1:0]  a_im_reg;
    logic signed [SW-1:0]  b_re_reg;
    logic signed [SW-1:0]  b_im_reg;
    logic signed [TW-1:0]  w_re_reg;
    logic signed [TW-1:0]  w_im_reg;

    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            kind_in_reg <= s_kind;
            fwd_in_reg  <= dir_fwd_reg;
            a_re_reg    <= s_top_re;
            a_im_reg    <= s_top_im;
            b_re_reg    <= s_bottom_re;
            b_im_reg    <= s_bottom_im;
            w_re_reg    <= s_twiddle_re;
            w_im_reg    <= s_twiddle_im;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: pair sums and differences, the four twiddle
    // products, and the complete answer for the non-pair kinds, which
    // is carried in the base fields.
    // ------------------------------------------------------------------
    logic signed [GW-1:0]  g_re;
    logic signed [GW-1:0]  g_im;
    logic signed [PW-1:0]  p_rr_next;
    logic signed [PW-1:0]  p_ii_next;
    logic signed [PW-1:0]  p_ri_next;
    logic signed [PW-1:0]  p_ir_next;
    logic signed [RW-1:0]  base_re_next;
    logic signed [RW-1:0]  base_im_next;
    logic signed [RW-1:0]  dc_re;
    logic signed [RW-1:0]  dc_im;

    always_comb begin
        g_re = GW'(a_im_reg) + GW'(b_im_reg);
        if (fwd_in_reg) begin
            g_im = GW'(b_re_reg) - GW'(a_re_reg);
        end else begin
            g_im = GW'(a_re_reg) - GW'(b_re_reg);
        end

        p_rr_next = PW'(w_re_reg) * PW'(g_re);
        p_ii_next = PW'(w_im_reg) * PW'(g_im);
        p_ri_next = PW'(w_re_reg) * PW'(g_im);
        p_ir_next = PW'(w_im_reg) * PW'(g_re);

        // Zero-frequency term; the forward transform doubles it first.
        dc_re = RW'(a_re_reg) + RW'(a_im_reg);
        dc_im = RW'(a_re_reg) - RW'(a_im_reg);
        if (fwd_in_reg) begin
            dc_re = dc_re <<< 1;
            dc_im = dc_im <<< 1;
        end

        unique case (kind_in_reg)
            rfft_ub_pkg::KIND_DC: begin
                base_re_next = dc_re;
                base_im_next = dc_im;
            end
            rfft_ub_pkg::KIND_PAIR: begin
                // h = a + conj(b) half of the butterfly.
                base_re_next = RW'(a_re_reg) + RW'(b_re_reg);
                base_im_next = RW'(a_im_reg) - RW'(b_im_reg);
            end
            rfft_ub_pkg::KIND_MID: begin
                base_re_next = RW'(a_re_reg) <<< 1;
                base_im_next = -(RW'(a_im_reg) <<< 1);
            end
            default: begin
                base_re_next = '0;
                base_im_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: product register.
    // ------------------------------------------------------------------
    logic [1:0]            kind_prod_reg;
    logic                  fwd_prod_reg;
    logic signed [PW-1:0]  p_rr_reg;
    logic signed [PW-1:0]  p_ii_reg;
    logic signed [PW-1:0]  p_ri_reg;
    logic signed [PW-1:0]  p_ir_reg;
    logic signed [RW-1:0]  base_re_reg;
    logic signed [RW-1:0]  base_im_reg;

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid_reg) begin
            kind_prod_reg <= kind_in_reg;
            fwd_prod_reg  <= fwd_in_reg;
            p_rr_reg      <= p_rr_next;
            p_ii_reg      <= p_ii_next;
            p_ri_reg      <= p_ri_next;
            p_ir_reg      <= p_ir_next;
            base_re_reg   <= base_re_next;
            base_im_reg   <= base_im_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: twiddle sums, floor shift out of Q1.F, final
    // butterfly add and saturation of all four outputs.
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] sum_re;
    logic signed [SUMW-1:0] sum_im;
    logic signed [TRW-1:0]  t_re;
    logic signed [TRW-1:0]  t_im;
    logic signed [RW-1:0]   x_re;
    logic signed [RW-1:0]   x_im;
    logic signed [RW-1:0]   y_re;
    logic signed [RW-1:0]   y_im;
    rfft_ub_pkg::sat_res_t  sat_x_re;
    rfft_ub_pkg::sat_res_t  sat_x_im;
    rfft_ub_pkg::sat_res_t  sat_y_re;
    rfft_ub_pkg::sat_res_t  sat_y_im;
    logic                   sat_next;

    always_comb begin
        sum_re = SUMW'(p_rr_reg) + SUMW'(p_ii_reg);
        sum_im = SUMW'(p_ri_reg) - SUMW'(p_ir_reg);
        // Dropping the low bits of a two's-complement value rounds toward
        // minus infinity.
        t_re = $signed(sum_re[SUMW-1:FB]);
        t_im = $signed(sum_im[SUMW-1:FB]);

        if (kind_prod_reg == rfft_ub_pkg::KIND_PAIR) begin
            if (fwd_prod_reg) begin
                x_re = base_re_reg + RW'(t_re);
                y_re = base_re_reg - RW'(t_re);
            end else begin
                x_re = base_re_reg - RW'(t_re);
                y_re = base_re_reg + RW'(t_re);
            end
            x_im = RW'(t_im) + base_im_reg;
            y_im = RW'(t_im) - base_im_reg;
        end else begin
            x_re = base_re_reg;
            x_im = base_im_reg;
            y_re = '0;
            y_im = '0;
        end

        sat_x_re = rfft_ub_pkg::saturate(x_re);
        sat_x_im = rfft_ub_pkg::saturate(x_im);
        sat_y_re = rfft_ub_pkg::saturate(y_re);
        sat_y_im = rfft_ub_pkg::saturate(y_im);
        sat_next = sat_x_re.clip | sat_x_im.clip | sat_y_re.clip | sat_y_im.clip;
    end

    // ------------------------------------------------------------------
    // Stage 3: result register, held while the receiver stalls.
    // ------------------------------------------------------------------
    logic [1:0]                  kind_out_reg;
    rfft_ub_pkg::out_word_t      top_re_reg;
    rfft_ub_pkg::out_word_t      top_im_reg;
    rfft_ub_pkg::out_word_t      bot_re_reg;
    rfft_ub_pkg::out_word_t      bot_im_reg;
    logic                        sat_reg;

    always_ff @(posedge aclk) begin
        if (out_ready && prod_valid_reg) begin
            kind_out_reg <= kind_prod_reg;
            top_re_reg   <= sat_x_re.value;
            top_im_reg   <= sat_x_im.value;
            bot_re_reg   <= sat_y_re.value;
            bot_im_reg   <= sat_y_im.value;
            sat_reg      <= sat_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_top_re    = top_re_reg;
    assign m_out_top_im    = top_im_reg;
    assign m_out_bottom_re = bot_re_reg;
    assign m_out_bottom_im = bot_im_reg;
    assign m_saturated     = sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !prod_valid_reg && !out_valid_reg))
        else $error("pipeline not empty after reset");

    // Only mirrored pairs produce a bottom result.
    a_bottom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_out_reg != rfft_ub_pkg::KIND_PAIR) |->
        (bot_re_reg == '0 && bot_im_reg == '0))
        else $error("non-pair word with nonzero bottom result");

    // A clipped result has at least one output pinned at a range limit.
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && sat_reg) |->
        (top_re_reg == rfft_ub_pkg::OUT_MAX || top_re_reg == rfft_ub_pkg::OUT_MIN ||
         top_im_reg == rfft_ub_pkg::OUT_MAX || top_im_reg == rfft_ub_pkg::OUT_MIN ||
         bot_re_reg == rfft_ub_pkg::OUT_MAX || bot_re_reg == rfft_ub_pkg::OUT_MIN ||
         bot_im_reg == rfft_ub_pkg::OUT_MAX || bot_im_reg == rfft_ub_pkg::OUT_MIN))
        else $error("saturation flag without a clipped output");

    // Middle and unused kinds can never overflow the output range.
    a_no_sat_simple: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_out_reg != rfft_ub_pkg::KIND_PAIR &&
         kind_out_reg != rfft_ub_pkg::KIND_DC) |-> !sat_reg)
        else $error("unexpected saturation on middle or unused kind");

    // A word in the product stage that cannot move keeps that stage full.
    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_valid_reg && !out_ready) |=> prod_valid_reg)
        else $error("product stage lost a stalled word");

endmodule

// ===== test/tb_real_fft_unpack_butterfly.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Real-FFT unpack butterfly testbench
// Feeds zero-frequency, mirrored-pair, middle and unused-kind words in both
// transform directions. Each result is checked against a behavioral split
// butterfly with floor-rounded twiddle products and 27-bit saturation.
// Both channels are throttled, and the receiver is stalled so that the
// block backs up.
// ----------------------------------------------------------------------------
module tb_real_fft_unpack_butterfly;

    // Kind code that the block treats as empty: it still returns an all-zero word.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Sample and twiddle extremes.
    localparam int S_MAX = (1 << (rfft_ub_pkg::SAMPLE_WIDTH - 1)) - 1;
    localparam int S_MIN = -S_MAX - 1;
    localparam int W_ONE = 1 << rfft_ub_pkg::TWIDDLE_FRAC_BITS;
    localparam int W_MAX = (1 << (rfft_ub_pkg::TWIDDLE_WIDTH - 1)) - 1;
    localparam int W_MIN = -W_MAX - 1;

    // Stalls and timeouts.
    localparam int RX_HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [1:0]                                    kind;
        logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]   top_re;
        logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]   top_im;
        logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]   bottom_re;
        logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]   bottom_im;
        logic signed [rfft_ub_pkg::TWIDDLE_WIDTH-1:0]  tw_re;
        logic signed [rfft_ub_pkg::TWIDDLE_WIDTH-1:0]  tw_im;
    } bfly_word_t;

    typedef struct packed {
        rfft_ub_pkg::out_word_t top_re;
        rfft_ub_pkg::out_word_t top_im;
        rfft_ub_pkg::out_word_t bottom_re;
        rfft_ub_pkg::out_word_t bottom_im;
        logic                   sat;
    } bfly_bins_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that the testbench drives. Every input of
    // the block starts at a known value.
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic                                           cfg_wr_en    = 1'b0;
    logic                                           cfg_wr_data  = 1'b0;
    logic                                           s_valid      = 1'b0;
    logic                                           s_ready;
    logic [1:0]                                     s_kind       = rfft_ub_pkg::KIND_DC;
    logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_top_re     = '0;
    logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_top_im     = '0;
    logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_bottom_re  = '0;
    logic signed [rfft_ub_pkg::SAMPLE_WIDTH-1:0]    s_bottom_im  = '0;
    logic signed [rfft_ub_pkg::TWIDDLE_WIDTH-1:0]   s_twiddle_re = '0;
    logic signed [rfft_ub_pkg::TWIDDLE_WIDTH-1:0]   s_twiddle_im = '0;
    logic                                           m_valid;
    logic                                           m_ready      = 1'b0;
    rfft_ub_pkg::out_word_t                         m_out_top_re;
    rfft_ub_pkg::out_word_t                         m_out_top_im;
    rfft_ub_pkg::out_word_t                         m_out_bottom_re;
    rfft_ub_pkg::out_word_t                         m_out_bottom_im;
    logic                                           m_saturated;

    real_fft_unpack_butterfly i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_top_re        (s_top_re),
        .s_top_im        (s_top_im),
        .s_bottom_re     (s_bottom_re),
        .s_bottom_im     (s_bottom_im),
        .s_twiddle_re    (s_twiddle_re),
        .s_twiddle_im    (s_twiddle_im),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_top_re    (m_out_top_re),
        .m_out_top_im    (m_out_top_im),
        .m_out_bottom_re (m_out_bottom_re),
        .m_out_bottom_im (m_out_bottom_im),
        .m_saturated     (m_saturated)
    );

    // ------------------------------------------------------------------------
    // Shared testbench state.
    // ------------------------------------------------------------------------
    bfly_word_t pending_words[$];   // words waiting for the driver
    bfly_bins_t expected_bins[$];   // predicted results, oldest first
    logic       fwd_mode      = 1'b1;   // our copy of direction_forward
    logic       word_taken    = 1'b0;   // input word accepted at the last edge
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         rx_hold_left  = 0;
    int         quiet_cycles  = 0;
    int         mismatch_count = 0;

    // ------------------------------------------------------------------------
    // Predictor. The arithmetic is done in 64 bits, which holds every
    // intermediate exactly: the twiddle products are 18 x 25 bits wide.
    // ------------------------------------------------------------------------
    function automatic rfft_ub_pkg::out_word_t clip_out(input longint v, inout logic hit);
        longint top_val;
        longint bot_val;
        top_val = (longint'(1) <<< (rfft_ub_pkg::OUT_WIDTH - 1)) - 1;
        bot_val = -top_val - 1;
        if (v > top_val) begin
            hit = 1'b1;
            return rfft_ub_pkg::out_word_t'(top_val);
        end
        if (v < bot_val) begin
            hit = 1'b1;
            return rfft_ub_pkg::out_word_t'(bot_val);
        end
        return rfft_ub_pkg::out_word_t'(v);
    endfunction

    function automatic bfly_bins_t split_butterfly(input bfly_word_t w, input logic fwd);
        bfly_bins_t res;
        longint     ar, ai, br, bi, wr, wi;
        longint     g_re, g_im, h_re, h_im, t_re, t_im;
        longint     x_re, x_im, y_re, y_im;
        logic       hit;
        ar   = longint'($signed(w.top_re));
        ai   = longint'($signed(w.top_im));
        br   = longint'($signed(w.bottom_re));
        bi   = longint'($signed(w.bottom_im));
        wr   = longint'($signed(w.tw_re));
        wi   = longint'($signed(w.tw_im));
        x_re = 0;
        x_im = 0;
        y_re = 0;
        y_im = 0;
        hit  = 1'b0;
        case (w.kind)
            rfft_ub_pkg::KIND_DC: begin
                // The forward transform doubles the zero-frequency term first.
                if (fwd) begin
                    ar = 2 * ar;
                    ai = 2 * ai;
                end
                x_re = ar + ai;
                x_im = ar - ai;
            end
            rfft_ub_pkg::KIND_PAIR: begin
                g_re = ai + bi;
                h_im = ai - bi;
                h_re = ar + br;
                g_im = fwd ? (br - ar) : (ar - br);
                // An arithmetic right shift of the exact sum rounds toward
                // minus infinity, as the block's truncating shift does.
                t_re = (wr * g_re + wi * g_im) >>> rfft_ub_pkg::TWIDDLE_FRAC_BITS;
                t_im = (wr * g_im - wi * g_re) >>> rfft_ub_pkg::TWIDDLE_FRAC_BITS;
                if (fwd) begin
                    x_re = h_re + t_re;
                    y_re = h_re - t_re;
                end else begin
                    x_re = h_re - t_re;
                    y_re = h_re + t_re;
                end
                x_im = t_im + h_im;
                y_im = t_im - h_im;
            end
            rfft_ub_pkg::KIND_MID: begin
                x_re = 2 * ar;
                x_im = -2 * ai;
            end
            default: begin
                // The unused kind returns all zeros, which the defaults give.
            end
        endcase
        res.top_re    = clip_out(x_re, hit);
        res.top_im    = clip_out(x_im, hit);
        res.bottom_re = clip_out(y_re, hit);
        res.bottom_im = clip_out(y_im, hit);
        res.sat       = hit;
        return res;
    endfunction

    // Every mismatch goes through here: one line per mismatch, and the count
    // decides the final message.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Inputs change at the falling edge only. A word stays on the bus
    // until the rising edge at which it is accepted; only then may the driver
    // idle or move on to the next pending word.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : drive_words
        bfly_word_t next_word;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word    = pending_words.pop_front();
                s_valid      <= 1'b1;
                s_kind       <= next_word.kind;
                s_top_re     <= next_word.top_re;
                s_top_im     <= next_word.top_im;
                s_bottom_re  <= next_word.bottom_re;
                s_bottom_im  <= next_word.bottom_im;
                s_twiddle_re <= next_word.tw_re;
                s_twiddle_im <= next_word.tw_im;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver. A requested hold-off is counted down here; otherwise the
    // ready line follows the current idle rate.
    always @(negedge aclk) begin : drive_ready
        if (rx_hold_left > 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. At the rising edge it sees the values from before the edge:
    // an accepted input word is predicted and queued, and an accepted result
    // word is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch_words
        bfly_word_t seen;
        bfly_bins_t want;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                seen.kind      = s_kind;
                seen.top_re    = s_top_re;
                seen.top_im    = s_top_im;
                seen.bottom_re = s_bottom_re;
                seen.bottom_im = s_bottom_im;
                seen.tw_re     = s_twiddle_re;
                seen.tw_im     = s_twiddle_im;
                expected_bins.push_back(split_butterfly(seen, fwd_mode));
            end
            if (m_valid && m_ready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch("result word with no input word outstanding");
                end else begin
                    want = expected_bins.pop_front();
                    check_field("out_top_re", m_out_top_re, want.top_re);
                    check_field("out_top_im", m_out_top_im, want.top_im);
                    check_field("out_bottom_re", m_out_bottom_re, want.bottom_re);
                    check_field("out_bottom_im", m_out_bottom_im, want.bottom_im);
                    check_field("saturated", m_saturated, want.sat);
                end
            end
        end
    end

    // Watchdog. It counts cycles in which work is outstanding but no word
    // moves on either channel. The receiver's long hold-off is well inside
    // the limit.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)
                || (!s_valid && expected_bins.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_real_fft_unpack_butterfly failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Words are queued at the rising edge so that they
    // never race the driver, which works at the falling edge.
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic [1:0] kind, input int ar, input int ai,
                              input int br, input int bi, input int wr, input int wi);
        bfly_word_t w;
        w.kind      = kind;
        w.top_re    = ar[rfft_ub_pkg::SAMPLE_WIDTH-1:0];
        w.top_im    = ai[rfft_ub_pkg::SAMPLE_WIDTH-1:0];
        w.bottom_re = br[rfft_ub_pkg::SAMPLE_WIDTH-1:0];
        w.bottom_im = bi[rfft_ub_pkg::SAMPLE_WIDTH-1:0];
        w.tw_re     = wr[rfft_ub_pkg::TWIDDLE_WIDTH-1:0];
        w.tw_im     = wi[rfft_ub_pkg::TWIDDLE_WIDTH-1:0];
        pending_words.push_back(w);
    endtask

    // Samples lean toward the extremes and small values, where saturation
    // and rounding are decided, but full-range values are the majority.
    function automatic int rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return $urandom_range(64) - 32;
            default: return $urandom();
        endcase
    endfunction

    // Twiddles are mostly legal Q1.16 values; a few use the whole field.
    function automatic int rand_twiddle();
        case ($urandom_range(9))
            0:       return W_ONE;
            1:       return -W_ONE;
            2:       return $urandom();
            default: return $urandom_range(2 * W_ONE) - W_ONE;
        endcase
    endfunction

    function automatic logic [1:0] rand_kind();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            return rfft_ub_pkg::KIND_PAIR;
        end else if (pick < 78) begin
            return rfft_ub_pkg::KIND_DC;
        end else if (pick < 95) begin
            return rfft_ub_pkg::KIND_MID;
        end
        return KIND_UNUSED;
    endfunction

    task automatic queue_random_words(input int count);
        @(posedge aclk);
        repeat (count) begin
            queue_word(rand_kind(), rand_sample(), rand_sample(), rand_sample(),
                       rand_sample(), rand_twiddle(), rand_twiddle());
        end
    endtask

    // Extremes of every field, every kind, rounding of negative sums,
    // out-of-range twiddles and the unused kind code.
    task automatic queue_directed_words();
        @(posedge aclk);
        queue_word(rfft_ub_pkg::KIND_DC,   S_MAX, S_MAX, 0, 0, 0, 0);
        queue_word(rfft_ub_pkg::KIND_DC,   S_MIN, S_MAX, 0, 0, 0, 0);
        queue_word(rfft_ub_pkg::KIND_DC,   S_MIN, S_MIN, 0, 0, 0, 0);
        queue_word(rfft_ub_pkg::KIND_PAIR, S_MAX, S_MAX, S_MAX, S_MAX, W_ONE, W_ONE);
        queue_word(rfft_ub_pkg::KIND_PAIR, S_MIN, S_MIN, S_MAX, S_MAX, -W_ONE, -W_ONE);
        queue_word(rfft_ub_pkg::KIND_PAIR, 1000, -2000, 3000, -4000, W_ONE, 0);
        queue_word(rfft_ub_pkg::KIND_PAIR, S_MAX, S_MIN, S_MIN, S_MAX, W_MIN, W_MAX);
        queue_word(rfft_ub_pkg::KIND_PAIR, 1, 3, 2, -1, 3, -5);
        queue_word(rfft_ub_pkg::KIND_PAIR, 0, 0, 0, 0, 0, 0);
        queue_word(rfft_ub_pkg::KIND_MID,  S_MAX, S_MIN, 0, 0, 0, 0);
        queue_word(rfft_ub_pkg::KIND_MID,  S_MIN, S_MAX, 0, 0, 0, 0);
        queue_word(KIND_UNUSED,            S_MAX, S_MIN, -1, S_MAX, W_MAX, W_MIN);
    endtask

    // Waits until every queued word has been accepted and every expected
    // result has arrived; this is also the sender's pause between phases.
    task automatic wait_until_idle();
        do begin
            @(posedge aclk);
        end while (pending_words.size() > 0 || s_valid || expected_bins.size() > 0);
    endtask

    // The direction register is written only while nothing is in flight, so
    // our copy can follow it at once.
    task automatic write_direction(input logic fwd);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fwd;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        fwd_mode     = fwd;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The sender idles 19 percent of the time, the receiver 46 percent.
        send_idle_pct = 19;
        recv_idle_pct = 46;

        // Directed words under the reset direction (forward), then inverse.
        queue_directed_words();
        wait_until_idle();
        write_direction(1'b0);
        queue_directed_words();
        wait_until_idle();

        queue_random_words(340);
        wait_until_idle();

        // The other way round, forward direction.
        send_idle_pct = 46;
        recv_idle_pct = 19;
        write_direction(1'b1);
        queue_random_words(340);
        wait_until_idle();

        // No idling on either side. The receiver first holds off for a long
        // stretch while the sender keeps offering words, so the pipeline
        // fills and s_ready must fall.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_direction(1'b0);
        @(posedge aclk);
        rx_hold_left = RX_HOLD_CYCLES;
        queue_random_words(40);
        wait_until_idle();

        write_direction(1'b1);
        queue_random_words(300);
        wait_until_idle();

        // Run on after the last result so that a stray extra result word is caught.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_real_fft_unpack_butterfly passed");
        end else begin
            $display("tb_real_fft_unpack_butterfly failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rfft_ub_pkg.sv
hw/rtl/real_fft_unpack_butterfly.sv
test/tb_real_fft_unpack_butterfly.sv
